FILE: hdl/ccr_pkg.sv
// Shared types, codes, constants and helper functions of the hex coordinate converter.
`timescale 1ns / 1ps

package ccr_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Operation codes
	localparam logic [1:0] MODE_CONVERT = 2'd0;
	localparam logic [1:0] MODE_ROUND   = 2'd1;
	localparam logic [1:0] MODE_SECTOR  = 2'd2;

	// Coordinate system codes
	localparam logic [1:0] SYS_ODDQ  = 2'd0;
	localparam logic [1:0] SYS_AXIAL = 2'd1;
	localparam logic [1:0] SYS_CUBIC = 2'd2;
	localparam logic [1:0] SYS_GRID  = 2'd3;

	// Sector table, indexed by {w<0, v<0, u<0}; SECTOR_NONE marks impossible sign patterns
	localparam logic [2:0] SECTOR_NONE = 3'd6;
	localparam logic [2:0] SECTOR_TAB [8] = '{
		3'd0, SECTOR_NONE, 3'd5, 3'd4,
		3'd1, 3'd2, SECTOR_NONE, 3'd3
	};

	// Divide-by-3 unit: floor(n / 3) = (n * DIV_RECIP) >> DIV_SHIFT for n < 2^DIV_SHIFT
	localparam int DIV_IN_W    = 33;
	localparam int DIV_Q_W     = 32;
	localparam int DIV_SHIFT   = 35;
	localparam int DIV_RECIP_W = 34;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
		DIV_RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd1) / 64'd3);

	// Decoupling queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int CREDIT_W = QCNT_W + 2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic [1:0]         src_system;
		logic [1:0]         dst_system;
	} ccr_in_t;

	typedef struct packed {
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic signed [31:0] z_out;
		logic [2:0]         sector;
		logic               sector_invalid;
	} ccr_out_t;

	// One classified item, already in axial form
	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         src_system;
		logic [1:0]         dst_system;
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic signed [31:0] ax;
		logic signed [32:0] ay;
	} ccr_job_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
		logic v_s3;
	} ccr_fstat_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} ccr_qstat_t;

	// Divide by 2, nearest, ties away from zero
	function automatic logic signed [32:0] div2_near(input logic signed [32:0] n);
		logic signed [32:0] t;
		t = n + (n[32] ? 33'sd0 : 33'sd1);
		return t >>> 1;
	endfunction

	// Magnitude of a 32-bit signed value
	function automatic logic [32:0] mag33(input logic signed [31:0] v);
		logic signed [32:0] e;
		e = 33'(v);
		return e[32] ? 33'(-e) : 33'(e);
	endfunction

endpackage

FILE: hdl/ccr_div3.sv
// Two-stage pipelined unsigned divide-by-3 by reciprocal multiplication.
`timescale 1ns / 1ps

module ccr_div3 import ccr_pkg::*; (
	input  logic                clk,
	input  logic [DIV_IN_W-1:0] num,
	output logic [DIV_Q_W-1:0]  quo
);

	localparam int LO_W  = DIV_RECIP_W / 2;
	localparam int NHI_W = DIV_IN_W - LO_W;
	localparam int RHI_W = DIV_RECIP_W - LO_W;
	localparam int PP_W  = DIV_RECIP_W;
	localparam int SUM_W = DIV_IN_W + DIV_RECIP_W;

	localparam logic [LO_W-1:0]  R_LO = DIV_RECIP[LO_W-1:0];
	localparam logic [RHI_W-1:0] R_HI = DIV_RECIP[DIV_RECIP_W-1:LO_W];

	logic [LO_W-1:0]  n_lo;
	logic [NHI_W-1:0] n_hi;
	logic [PP_W-1:0]  pp_hh_s2, pp_hl_s2, pp_lh_s2, pp_ll_s2;
	logic [SUM_W-1:0] sum;
	logic [DIV_Q_W-1:0] quo_s3;

	assign n_lo = num[LO_W-1:0];
	assign n_hi = num[DIV_IN_W-1:LO_W];

	// partial products, registered
	always_ff @(posedge clk) begin
		pp_hh_s2 <= PP_W'(n_hi) * PP_W'(R_HI);
		pp_hl_s2 <= PP_W'(n_hi) * PP_W'(R_LO);
		pp_lh_s2 <= PP_W'(n_lo) * PP_W'(R_HI);
		pp_ll_s2 <= PP_W'(n_lo) * PP_W'(R_LO);
	end

	assign sum = (SUM_W'(pp_hh_s2) << (2 * LO_W))
		+ (SUM_W'(pp_hl_s2) << LO_W)
		+ (SUM_W'(pp_lh_s2) << LO_W)
		+ SUM_W'(pp_ll_s2);

	always_ff @(posedge clk) begin
		quo_s3 <= sum[SUM_W-1:DIV_SHIFT];
	end

	assign quo = quo_s3;

endmodule

FILE: hdl/ccr_front.sv
// Front end: accept an item, bring it to axial form through a three-stage pipeline.
`timescale 1ns / 1ps

module ccr_front import ccr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  ccr_in_t    cmd,
	output ccr_fstat_t fstat,
	output logic       push,
	output ccr_job_t   job
);

	localparam logic signed [32:0] ONE_Q = 33'sd1 <<< FRAC_BITS;

	logic    v_s1, v_s2, v_s3;
	ccr_in_t cmd_s1, cmd_s2, cmd_s3;
	logic    xneg_s2, xneg_s3, n6neg_s2, n6neg_s3;

	logic [32:0]        x_mag;
	logic [DIV_IN_W-1:0] num_x, num_6;
	logic signed [34:0] n6;
	logic [34:0]        n6_mag, n6_rnd;
	logic [DIV_Q_W-1:0] q_x, q_6;

	logic [32:0]        xs3_mag;
	logic signed [32:0] oddq_n, oddq_half;
	logic signed [31:0] ax_grid, ay_grid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= cmd;
		cmd_s2   <= cmd_s1;
		cmd_s3   <= cmd_s2;
		xneg_s2  <= cmd_s1.x_in[31];
		xneg_s3  <= xneg_s2;
		n6neg_s2 <= n6[34];
		n6neg_s3 <= n6neg_s2;
	end

	// grid numerators: |x| + 1 for x/3, (|3y - x| + 3) / 2 for the /6
	always_comb begin
		x_mag  = mag33(cmd_s1.x_in);
		num_x  = DIV_IN_W'(x_mag + 33'd1);
		n6     = (35'(cmd_s1.y_in) <<< 1) + 35'(cmd_s1.y_in) - 35'(cmd_s1.x_in);
		n6_mag = n6[34] ? 35'(-n6) : 35'(n6);
		n6_rnd = n6_mag + 35'd3;
		num_6  = n6_rnd[DIV_IN_W:1];
	end

	ccr_div3 u_div_x (.clk(clk), .num(num_x), .quo(q_x));
	ccr_div3 u_div_6 (.clk(clk), .num(num_6), .quo(q_6));

	always_comb begin
		xs3_mag   = mag33(cmd_s3.x_in);
		oddq_n    = 33'(cmd_s3.x_in) - (xs3_mag[FRAC_BITS] ? ONE_Q : 33'sd0);
		oddq_half = div2_near(oddq_n);
		ax_grid   = xneg_s3 ? -$signed(q_x) : $signed(q_x);
		ay_grid   = n6neg_s3 ? -$signed(q_6) : $signed(q_6);

		job.mode       = cmd_s3.mode;
		job.src_system = cmd_s3.src_system;
		job.dst_system = cmd_s3.dst_system;
		job.x_in       = cmd_s3.x_in;
		job.y_in       = cmd_s3.y_in;
		case (cmd_s3.src_system)
			SYS_ODDQ: begin
				job.ax = cmd_s3.x_in;
				job.ay = 33'(cmd_s3.y_in) - oddq_half;
			end
			SYS_GRID: begin
				job.ax = ax_grid;
				job.ay = 33'(ay_grid);
			end
			default: begin
				job.ax = cmd_s3.x_in;
				job.ay = 33'(cmd_s3.y_in);
			end
		endcase
	end

	assign push       = v_s3;
	assign fstat.v_s1 = v_s1;
	assign fstat.v_s2 = v_s2;
	assign fstat.v_s3 = v_s3;

endmodule

FILE: hdl/ccr_queue.sv
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module ccr_queue import ccr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ccr_job_t   push_data,
	input  logic       pop,
	output ccr_job_t   head,
	output ccr_qstat_t qstat
);

	ccr_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

endmodule

FILE: hdl/ccr_back.sv
// Back end: target conversion, tile rounding or sector lookup, into the result register.
`timescale 1ns / 1ps

module ccr_back import ccr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  ccr_job_t head,
	output logic     pop,
	output logic     done,
	output ccr_out_t result
);

	localparam int RW = FRAC_BITS + 3;
	localparam logic signed [32:0] ONE_Q  = 33'sd1 <<< FRAC_BITS;
	localparam logic signed [32:0] HALF_Q = 33'sd1 <<< (FRAC_BITS - 1);
	localparam logic [31:0]        ONE32  = 32'd1 << FRAC_BITS;
	localparam logic signed [RW-1:0] ONE_R  = RW'(1) <<< FRAC_BITS;
	localparam logic signed [RW-1:0] HALF_R = RW'(1) <<< (FRAC_BITS - 1);

	ccr_out_t res_c, res_q;
	logic     done_q;

	logic [31:0]        ayl;
	logic [32:0]        ax_mag;
	logic signed [32:0] oq_n, oq_half, oq_y;
	logic signed [32:0] hx;
	logic signed [33:0] hy;
	logic signed [RW-1:0] ra, rb, ru, rv, rw;
	logic               x_inc, x_dec, y_inc, y_dec;
	logic signed [34:0] su, sv, sw;
	logic [2:0]         sec_raw;

	always_comb begin
		ayl     = head.ay[31:0];
		ax_mag  = mag33(head.ax);
		oq_n    = 33'(head.ax) - (ax_mag[FRAC_BITS] ? ONE_Q : 33'sd0);
		oq_half = div2_near(oq_n);
		oq_y    = head.ay + oq_half;

		// tile rounding: nearest integer, then a hexagon correction from the remainders
		hx = 33'(head.ax) + HALF_Q;
		hy = 34'(head.ay) + 34'(HALF_Q);
		ra = $signed(RW'(hx[FRAC_BITS-1:0])) - HALF_R;
		rb = $signed(RW'(hy[FRAC_BITS-1:0])) - HALF_R;
		ru = ra + (rb <<< 1);
		rv = (ra <<< 1) + rb;
		rw = rb - ra;
		x_inc = 1'b0;
		x_dec = 1'b0;
		y_inc = 1'b0;
		y_dec = 1'b0;
		if (rw < 0) begin
			if (ru < -ONE_R) y_dec = 1'b1;
			else if (rv > ONE_R) x_inc = 1'b1;
		end else begin
			if (rv < -ONE_R) x_dec = 1'b1;
			else if (ru > ONE_R) y_inc = 1'b1;
		end

		// sector signs on the exact axial vector
		su = 35'(head.ax) + (35'(head.ay) <<< 1);
		sv = (35'(head.ax) <<< 1) + 35'(head.ay);
		sw = 35'(head.ay) - 35'(head.ax);
		sec_raw = SECTOR_TAB[{sw[34], sv[34], su[34]}];

		res_c = '0;
		case (head.mode)
			MODE_CONVERT: begin
				if (head.src_system == head.dst_system) begin
					res_c.x_out = head.x_in;
					res_c.y_out = head.y_in;
					if (head.dst_system == SYS_CUBIC) begin
						res_c.z_out = head.x_in - head.y_in;
					end
				end else begin
					case (head.dst_system)
						SYS_ODDQ: begin
							res_c.x_out = head.ax;
							res_c.y_out = oq_y[31:0];
						end
						SYS_AXIAL: begin
							res_c.x_out = head.ax;
							res_c.y_out = ayl;
						end
						SYS_CUBIC: begin
							res_c.x_out = head.ax;
							res_c.y_out = ayl;
							res_c.z_out = head.ax - ayl;
						end
						default: begin
							res_c.x_out = (head.ax <<< 1) + head.ax;
							res_c.y_out = (ayl << 1) + head.ax;
						end
					endcase
				end
			end
			MODE_ROUND: begin
				res_c.x_out = {hx[31:FRAC_BITS], {FRAC_BITS{1'b0}}}
					+ (x_inc ? ONE32 : (x_dec ? -ONE32 : 32'd0));
				res_c.y_out = {hy[31:FRAC_BITS], {FRAC_BITS{1'b0}}}
					+ (y_inc ? ONE32 : (y_dec ? -ONE32 : 32'd0));
			end
			MODE_SECTOR: begin
				if (sec_raw == SECTOR_NONE) begin
					res_c.sector_invalid = 1'b1;
				end else begin
					res_c.sector = sec_raw;
				end
			end
			default: begin
				res_c = '0;
			end
		endcase
	end

	assign pop = !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_c;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: hdl/hex_coord_convert_round_core.sv
// Top level of the hex grid coordinate converter: front, queue and back.
//
//   channel   | handshake            | payload            | direction
//   ----------+----------------------+--------------------+----------
//   command   | start high, busy low | cmd    (ccr_in_t)  | in
//   result    | done strobe, 1 cycle | result (ccr_out_t) | out
//
// One transaction per cycle sustained; each transaction passes from accept to
// its done strobe through 3 front stages (the divide-by-3 units are two pipelined
// stages, partial products then quotient), 1 queue slot, 1 back-end result register.
// Reset (arst_n low) clears all valid bits and queue pointers; no clearing pass.
// The receiver cannot stall, so the back end pops the queue every cycle it is
// non-empty; busy comes from a credit count of front stages plus queue fill.
`timescale 1ns / 1ps

module hex_coord_convert_round_core import ccr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ccr_in_t  cmd,
	output logic     done,
	output ccr_out_t result
);

	logic       accept;
	ccr_fstat_t fstat;
	ccr_qstat_t qstat;
	logic       push, pop;
	ccr_job_t   job, head;
	logic [CREDIT_W-1:0] used;

	// accept a transaction only when a queue slot is guaranteed for it
	assign accept = start && !busy;

	// count items that will need a slot, minus the one popped this cycle
	assign used = CREDIT_W'(fstat.v_s1) + CREDIT_W'(fstat.v_s2) + CREDIT_W'(fstat.v_s3)
		+ CREDIT_W'(qstat.count) - CREDIT_W'(pop);
	assign busy = (used >= CREDIT_W'(QDEPTH));

	// front: hold the command, divide, and bring it to axial form
	ccr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.fstat  (fstat),
		.push   (push),
		.job    (job)
	);

	// queue: decouple front and back
	ccr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// back: finish the operation and drive the result strobe
	ccr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (qstat.empty),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

endmodule

FILE: hdl/ccr_checker.sv
// Port-level assertions for the hex coordinate converter, bound to the top level.
`timescale 1ns / 1ps

module ccr_checker import ccr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input ccr_in_t  cmd,
	input logic     done,
	input ccr_out_t result
);

	localparam int LAT = 5;

	// every accepted transaction strobes its result a fixed latency later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted command produced no result strobe");

	// a strobe only follows an accepted transaction
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe does not match accepted command");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.mode, LAT) == MODE_SECTOR
		|-> result.x_out == 32'sd0 && result.y_out == 32'sd0 && result.z_out == 32'sd0
		&& result.sector <= 3'd5 && (!result.sector_invalid || result.sector == 3'd0))
		else $error("sector result out of range or carries coordinates");

	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.mode, LAT) == MODE_CONVERT
		&& $past(cmd.src_system, LAT) == $past(cmd.dst_system, LAT)
		|-> result.x_out == $past(cmd.x_in, LAT) && result.y_out == $past(cmd.y_in, LAT))
		else $error("same-system conversion altered the position");

	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.mode, LAT) == MODE_ROUND
		|-> result.z_out == 32'sd0 && result.x_out[FRAC_BITS-1:0] == '0
		&& result.y_out[FRAC_BITS-1:0] == '0)
		else $error("rounded tile centre is not integral");

endmodule

bind hex_coord_convert_round_core ccr_checker #(.FRAC_BITS(FRAC_BITS)) u_ccr_checker (.*);

FILE: dv/hex_coord_convert_round_core_test.sv
// Self-checking testbench of the hex coordinate converter core with a predicting scoreboard.
`timescale 1ns / 1ps

module hex_coord_convert_round_core_test;
	import ccr_pkg::*;

	localparam int    FB     = FRAC_BITS_DEF;
	localparam longint ONE_Q = longint'(1) << FB;
	localparam int    HALF_Q = 1 << (FB - 1);

	// Mode code that the block leaves unused: it answers with an all-zero result
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Sector by sign pattern {w<0, v<0, u<0}; NO_SECTOR marks patterns no vector can have
	localparam logic [2:0] NO_SECTOR = 3'd6;
	localparam logic [2:0] SECTOR_OF_SIGNS [8] = '{
		3'd0, NO_SECTOR, 3'd5, 3'd4,
		3'd1, 3'd2, NO_SECTOR, 3'd3
	};

	typedef struct {
		ccr_in_t  cmd;
		ccr_out_t want;
	} hex_expect_t;

	// Scoreboard: predict each accepted transaction, match results in order
	class hex_result_board;
		hex_expect_t pending_results[$];
		int unsigned faults;

		function void report(string what);
			faults++;
			if (faults <= 100)
				$display("MISMATCH @%0t: %s", $realtime, what);
		endfunction

		// Divide by a small positive constant, nearest, ties away from zero
		function longint div_nearest(longint n, longint d);
			if (n >= 0)
				return (n + d / 2) / d;
			return -((-n + d / 2) / d);
		endfunction

		// Parity of the integer part truncated toward zero, as a Q value
		function longint odd_parity_q(longint q);
			longint m;
			m = (q < 0) ? -q : q;
			return (((m >>> FB) & 1) != 0) ? ONE_Q : 0;
		endfunction

		function ccr_out_t expected_hex_result(ccr_in_t c);
			ccr_out_t r;
			longint x, y, ax, ay, ix, iy, a, b, u, v, w;
			logic [2:0] idx;
			logic [2:0] s;
			x = longint'($signed(c.x_in));
			y = longint'($signed(c.y_in));
			r = '0;
			// bring the position into axial form, exactly wide
			case (c.src_system)
				SYS_ODDQ: begin
					ax = x;
					ay = y - div_nearest(x - odd_parity_q(x), 2);
				end
				SYS_GRID: begin
					ax = div_nearest(x, 3);
					ay = div_nearest(3 * y - x, 6);
				end
				default: begin
					ax = x;
					ay = y;
				end
			endcase
			case (c.mode)
				MODE_CONVERT: begin
					if (c.src_system == c.dst_system) begin
						r.x_out = c.x_in;
						r.y_out = c.y_in;
						if (c.dst_system == SYS_CUBIC)
							r.z_out = 32'(x - y);
					end else begin
						case (c.dst_system)
							SYS_ODDQ: begin
								r.x_out = 32'(ax);
								r.y_out = 32'(ay + div_nearest(ax - odd_parity_q(ax), 2));
							end
							SYS_AXIAL: begin
								r.x_out = 32'(ax);
								r.y_out = 32'(ay);
							end
							SYS_CUBIC: begin
								r.x_out = 32'(ax);
								r.y_out = 32'(ay);
								r.z_out = 32'(ax - ay);
							end
							default: begin
								r.x_out = 32'(3 * ax);
								r.y_out = 32'(2 * ay + ax);
							end
						endcase
					end
				end
				MODE_ROUND: begin
					ix = (ax + ONE_Q / 2) >>> FB;
					iy = (ay + ONE_Q / 2) >>> FB;
					a = ax - ix * ONE_Q;
					b = ay - iy * ONE_Q;
					u = a + 2 * b;
					v = 2 * a + b;
					w = b - a;
					if (w < 0) begin
						if (u < -ONE_Q)
							iy--;
						else if (v > ONE_Q)
							ix++;
					end else begin
						if (v < -ONE_Q)
							ix--;
						else if (u > ONE_Q)
							iy++;
					end
					r.x_out = 32'(ix * ONE_Q);
					r.y_out = 32'(iy * ONE_Q);
				end
				MODE_SECTOR: begin
					u = ax + 2 * ay;
					v = 2 * ax + ay;
					w = ay - ax;
					idx = {w < 0, v < 0, u < 0};
					s = SECTOR_OF_SIGNS[idx];
					if (s == NO_SECTOR)
						r.sector_invalid = 1'b1;
					else
						r.sector = s;
				end
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_command(ccr_in_t c);
			hex_expect_t e;
			e.cmd = c;
			e.want = expected_hex_result(c);
			pending_results.push_back(e);
		endfunction

		function void check_result(ccr_out_t got);
			hex_expect_t e;
			string tag;
			if (pending_results.size() == 0) begin
				report($sformatf("result with no transaction outstanding: %h", got));
				return;
			end
			e = pending_results.pop_front();
			tag = $sformatf("mode %0d src %0d dst %0d x %h y %h:", e.cmd.mode,
				e.cmd.src_system, e.cmd.dst_system, e.cmd.x_in, e.cmd.y_in);
			if (got.x_out !== e.want.x_out)
				report($sformatf("%s x_out %h, want %h", tag, got.x_out, e.want.x_out));
			if (got.y_out !== e.want.y_out)
				report($sformatf("%s y_out %h, want %h", tag, got.y_out, e.want.y_out));
			if (got.z_out !== e.want.z_out)
				report($sformatf("%s z_out %h, want %h", tag, got.z_out, e.want.z_out));
			if (got.sector !== e.want.sector)
				report($sformatf("%s sector %0d, want %0d", tag, got.sector, e.want.sector));
			if (got.sector_invalid !== e.want.sector_invalid)
				report($sformatf("%s sector_invalid %b, want %b", tag,
					got.sector_invalid, e.want.sector_invalid));
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	ccr_in_t  cmd;
	logic     done;
	ccr_out_t result;

	hex_result_board board = new();

	hex_coord_convert_round_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// The receiver cannot stall: take every strobed result at the edge that ends it
	always @(posedge clk) begin
		if (done)
			board.check_result(result);
	end

	function automatic ccr_in_t make_cmd(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
		logic [1:0] src, logic [1:0] dst);
		ccr_in_t c;
		c.mode = mode;
		c.x_in = x;
		c.y_in = y;
		c.src_system = src;
		c.dst_system = dst;
		return c;
	endfunction

	// Coordinate mix: full range, near the origin, exact and half tiles, extremes
	function automatic logic signed [31:0] pick_coord();
		logic signed [31:0] q;
		case ($urandom_range(0, 5))
			0, 1: q = $urandom();
			2: q = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			3: q = ((int'($urandom_range(0, 40)) - 20) <<< FB)
				+ (($urandom_range(0, 1) != 0) ? HALF_Q : 0);
			default: begin
				case ($urandom_range(0, 5))
					0: q = 32'sh8000_0000;
					1: q = 32'sh7fff_ffff;
					2: q = 32'sh0;
					3: q = -32'sd1;
					4: q = 32'(ONE_Q);
					default: q = -32'(ONE_Q);
				endcase
			end
		endcase
		return q;
	endfunction

	function automatic ccr_in_t random_command();
		ccr_in_t c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			c.mode = MODE_CONVERT;
		else if (r < 65)
			c.mode = MODE_ROUND;
		else if (r < 94)
			c.mode = MODE_SECTOR;
		else
			c.mode = MODE_SPARE;
		c.x_in = pick_coord();
		c.y_in = pick_coord();
		c.src_system = 2'($urandom_range(0, 3));
		c.dst_system = 2'($urandom_range(0, 3));
		return c;
	endfunction

	// Present one transaction and hold it until the edge that accepts it
	task automatic send_command(input ccr_in_t c);
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_command(c);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and hold until every outstanding transaction has answered
	task automatic hold_until_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.pending_results.size() != 0);
	endtask

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [31:0] corner [8];
		int unsigned gap;
		int unsigned r;
		bit dense;
		corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'h0001_8000, 32'hfffe_8000, 32'h0003_0000, 32'h0000_8000};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every source/target pair on corner values, back to back
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < 4; d++)
				send_command(make_cmd(MODE_CONVERT, corner[(s * 4 + d) % 8],
					corner[(s * 4 + d + 3) % 8], 2'(s), 2'(d)));
		end
		// Tile rounding: a tie on both axes, and a remainder that steps y down
		send_command(make_cmd(MODE_ROUND, HALF_Q, -HALF_Q, SYS_AXIAL, SYS_ODDQ));
		send_command(make_cmd(MODE_ROUND, -32'sh4ccd, -32'sh7d71, SYS_AXIAL, SYS_ODDQ));
		// Sector around four axial directions, a grid-source vector and the zero vector
		send_command(make_cmd(MODE_SECTOR, 32'(ONE_Q), 0, SYS_AXIAL, SYS_AXIAL));
		send_command(make_cmd(MODE_SECTOR, 0, 32'(ONE_Q), SYS_AXIAL, SYS_AXIAL));
		send_command(make_cmd(MODE_SECTOR, -32'(ONE_Q), 32'(ONE_Q), SYS_AXIAL, SYS_AXIAL));
		send_command(make_cmd(MODE_SECTOR, -32'(ONE_Q), 0, SYS_CUBIC, SYS_AXIAL));
		send_command(make_cmd(MODE_SECTOR, 32'(ONE_Q), -32'(ONE_Q), SYS_GRID, SYS_AXIAL));
		send_command(make_cmd(MODE_SECTOR, 0, 0, SYS_ODDQ, SYS_AXIAL));
		send_command(make_cmd(MODE_SPARE, 32'h7fff_ffff, 32'h8000_0000, SYS_GRID, SYS_GRID));

		// Random: each segment is either full rate or gappy traffic
		dense = 1'b0;
		for (int n = 0; n < 1150; n++) begin
			if (n % 100 == 0)
				dense = ($urandom_range(0, 2) == 0);
			if (n == 600 || $urandom_range(0, 199) == 0) begin
				hold_until_drained();
			end else if (!dense) begin
				r = $urandom_range(0, 99);
				if (r < 55)
					gap = 0;
				else if (r < 85)
					gap = $urandom_range(1, 3);
				else if (r < 97)
					gap = $urandom_range(4, 12);
				else
					gap = $urandom_range(20, 60);
				if (gap != 0)
					pause_sender(gap);
			end
			send_command(random_command());
		end

		hold_until_drained();
		// Leave room for any stray strobe past the pipeline depth
		repeat (10) @(posedge clk);
		if (board.faults == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
